/* rtl/pfr_pkg.sv */
// Shared constants and types for the polynomial-from-roots expander.
`default_nettype none

package pfr_pkg;

    localparam int MAX_DEGREE = 8;
    localparam int CNT_W      = $clog2(MAX_DEGREE + 1);

    localparam int ROOT_W  = 24;
    localparam int COEF_W  = 64;
    localparam int IDX_W   = 3;
    localparam int DEG_W   = 4;
    localparam int FRAC_W  = 20;
    localparam int HALF_W  = COEF_W / 2;
    localparam int MULA_W  = HALF_W + 1;
    localparam int PROD_W  = MULA_W + ROOT_W;
    localparam int ACC_W   = COEF_W + ROOT_W + 2;
    localparam int SH_W    = ACC_W - FRAC_W;
    localparam int DIFF_W  = SH_W + 1;
    localparam int OP_W    = 3;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DEGREE = '0;
    localparam logic [DEG_W-1:0]     DEG_RESET  = DEG_W'(2);

    localparam logic [OP_W-1:0]   OP_FIRST = '0;
    localparam logic [OP_W-1:0]   OP_LAST  = '1;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;
    localparam logic [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (FRAC_W - 1);

    typedef struct packed {
        logic            vld;
        logic            clr;
        logic [OP_W-1:0] op;
    } t_mac_ctl;

endpackage

`default_nettype wire

/* rtl/pfr_root_if.sv */
// Handshake channel that carries one complex root.
`default_nettype none

interface pfr_root_if import pfr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ROOT_W-1:0] root_real;
    logic signed [ROOT_W-1:0] root_imag;

    modport source (output valid, root_real, root_imag, input ready);
    modport sink (input valid, root_real, root_imag, output ready);
endinterface

`default_nettype wire

/* rtl/pfr_coef_if.sv */
// Handshake channel that carries one complex coefficient.
`default_nettype none

interface pfr_coef_if import pfr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_real;
    logic signed [COEF_W-1:0] coef_imag;
    logic                     last_coef;

    modport source (output valid, coef_index, coef_real, coef_imag, last_coef, input ready);
    modport sink (input valid, coef_index, coef_real, coef_imag, last_coef, output ready);
endinterface

`default_nettype wire

/* rtl/polynomial_from_roots_expander.sv */
// Top level of the polynomial-from-roots expander: sequencer, coefficient store, ports.
//
//   Channel   Direction  Payload                                      Handshake
//   i_root    in         root_real, root_imag (Q3.20)                 valid / ready
//   o_coef    out        coef_index, coef_real, coef_imag, last_coef  valid / ready
//   APB       in / out   degree register at byte address 0            psel, penable, pwrite
//
// A root with n roots already held updates n + 2 coefficients: each of them passes
// eight 33 x 24 partial products through the one shared multiplier, then a drain state
// and a write-back state. A root that completes a run is followed by MAX_DEGREE output
// coefficients, one per cycle while the sink is ready.
// Reset is synchronous and restores the polynomial 1 and a degree of two.
// The block takes no root while it works; a stalled sink holds the output register.
`default_nettype none

module polynomial_from_roots_expander import pfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pfr_root_if.sink           i_root,
    pfr_coef_if.source         o_coef,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_WB,
        S_EMIT
    } t_state;

    t_state                   r_state, n_state;
    logic [DEG_W-1:0]         r_degree, n_degree;
    logic [CNT_W-1:0]         r_roots, n_roots;
    logic [CNT_W-1:0]         r_k, n_k;
    logic [CNT_W-1:0]         r_j, n_j;
    logic [OP_W-1:0]          r_op, n_op;
    logic signed [ROOT_W-1:0] r_rr, n_rr;
    logic signed [ROOT_W-1:0] r_ri, n_ri;
    logic [COEF_W-1:0]        r_poly_re [MAX_DEGREE+1];
    logic [COEF_W-1:0]        n_poly_re [MAX_DEGREE+1];
    logic [COEF_W-1:0]        r_poly_im [MAX_DEGREE+1];
    logic [COEF_W-1:0]        n_poly_im [MAX_DEGREE+1];
    logic                     r_out_vld, n_out_vld;
    logic [IDX_W-1:0]         r_out_idx, n_out_idx;
    logic [COEF_W-1:0]        r_out_re, n_out_re;
    logic [COEF_W-1:0]        r_out_im, n_out_im;
    logic                     r_out_last, n_out_last;

    logic [CNT_W-1:0]  eff;
    logic [CNT_W-1:0]  cur;
    logic [CNT_W-1:0]  rd_addr;
    logic [COEF_W-1:0] rd_re;
    logic [COEF_W-1:0] rd_im;
    logic [COEF_W-1:0] base_re;
    logic [COEF_W-1:0] base_im;
    logic [COEF_W-1:0] new_re;
    logic [COEF_W-1:0] new_im;
    t_mac_ctl          mac_ctl;
    logic              cfg_wr;
    logic              reg_hit;
    logic              root_take;
    logic              out_free;

    pfr_cmac u_cmac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_p_re    (rd_re),
        .i_p_im    (rd_im),
        .i_r_re    (r_rr),
        .i_r_im    (r_ri),
        .i_base_re (base_re),
        .i_base_im (base_im),
        .o_new_re  (new_re),
        .o_new_im  (new_im)
    );

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_DEGREE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_hit ? PDATA_W'(r_degree) : '0;

    assign i_root.ready      = (r_state == S_IDLE);
    assign root_take         = i_root.valid && i_root.ready;
    assign o_coef.valid      = r_out_vld;
    assign o_coef.coef_index = r_out_idx;
    assign o_coef.coef_real  = r_out_re;
    assign o_coef.coef_imag  = r_out_im;
    assign o_coef.last_coef  = r_out_last;
    assign out_free          = !r_out_vld || o_coef.ready;

    always_comb begin
        if (r_degree == '0) begin
            eff = CNT_W'(1);
        end else if (int'(r_degree) > MAX_DEGREE) begin
            eff = CNT_W'(MAX_DEGREE);
        end else begin
            eff = CNT_W'(r_degree);
        end
        if (int'(r_roots) > MAX_DEGREE - 1) begin
            cur = CNT_W'(MAX_DEGREE - 1);
        end else begin
            cur = r_roots;
        end
    end

    always_comb begin
        case (r_state)
            S_WB:    rd_addr = r_k - CNT_W'(1);
            S_EMIT:  rd_addr = r_j;
            default: rd_addr = r_k;
        endcase
        rd_re = r_poly_re[rd_addr];
        rd_im = r_poly_im[rd_addr];
        if (r_k == '0) begin
            base_re = '0;
            base_im = '0;
        end else begin
            base_re = rd_re;
            base_im = rd_im;
        end
        mac_ctl.vld = (r_state == S_MUL);
        mac_ctl.clr = (r_op == OP_FIRST);
        mac_ctl.op  = r_op;
    end

    always_comb begin
        n_state    = r_state;
        n_degree   = r_degree;
        n_roots    = r_roots;
        n_k        = r_k;
        n_j        = r_j;
        n_op       = r_op;
        n_rr       = r_rr;
        n_ri       = r_ri;
        n_poly_re  = r_poly_re;
        n_poly_im  = r_poly_im;
        n_out_vld  = r_out_vld;
        n_out_idx  = r_out_idx;
        n_out_re   = r_out_re;
        n_out_im   = r_out_im;
        n_out_last = r_out_last;

        if (cfg_wr && reg_hit) begin
            n_degree = pwdata[DEG_W-1:0];
        end
        if (r_out_vld && o_coef.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (root_take) begin
                    n_rr    = i_root.root_real;
                    n_ri    = i_root.root_imag;
                    n_k     = cur + CNT_W'(1);
                    n_op    = OP_FIRST;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_op = r_op + OP_W'(1);
                if (r_op == OP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_poly_re[r_k] = new_re;
                n_poly_im[r_k] = new_im;
                n_op           = OP_FIRST;
                if (r_k == '0) begin
                    n_roots = cur + CNT_W'(1);
                    if (cur + CNT_W'(1) >= eff) begin
                        n_j     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_k     = r_k - CNT_W'(1);
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_idx  = IDX_W'(r_j);
                    n_out_re   = (r_j < eff) ? rd_re : '0;
                    n_out_im   = (r_j < eff) ? rd_im : '0;
                    n_out_last = (r_j == CNT_W'(MAX_DEGREE - 1));
                    n_j        = r_j + CNT_W'(1);
                    if (r_j == CNT_W'(MAX_DEGREE - 1)) begin
                        for (int i = 0; i <= MAX_DEGREE; i++) begin
                            n_poly_re[i] = '0;
                            n_poly_im[i] = '0;
                        end
                        n_poly_re[0] = COEF_ONE;
                        n_roots      = '0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_degree  <= DEG_RESET;
            r_roots   <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_op      <= OP_FIRST;
            r_out_vld <= 1'b0;
            for (int i = 0; i <= MAX_DEGREE; i++) begin
                r_poly_re[i] <= (i == 0) ? COEF_ONE : '0;
                r_poly_im[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_degree  <= n_degree;
            r_roots   <= n_roots;
            r_k       <= n_k;
            r_j       <= n_j;
            r_op      <= n_op;
            r_out_vld <= n_out_vld;
            r_poly_re <= n_poly_re;
            r_poly_im <= n_poly_im;
        end
        r_rr       <= n_rr;
        r_ri       <= n_ri;
        r_out_idx  <= n_out_idx;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

/* rtl/pfr_cmac.sv */
// Shared complex multiply-accumulate unit with rounding, subtraction and saturation.
`default_nettype none

module pfr_cmac import pfr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic [COEF_W-1:0]        i_p_re,
    input  logic [COEF_W-1:0]        i_p_im,
    input  logic signed [ROOT_W-1:0] i_r_re,
    input  logic signed [ROOT_W-1:0] i_r_im,
    input  logic [COEF_W-1:0]        i_base_re,
    input  logic [COEF_W-1:0]        i_base_im,
    output logic [COEF_W-1:0]        o_new_re,
    output logic [COEF_W-1:0]        o_new_im
);

    logic [COEF_W-1:0]        p_sel;
    logic signed [MULA_W-1:0] mul_a;
    logic signed [ROOT_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_hi;
    logic                     r_prod_neg;
    logic                     r_prod_imag;

    logic signed [ACC_W-1:0] term_ext;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;

    function automatic logic [COEF_W-1:0] sub_sat(input logic [COEF_W-1:0] base,
                                                  input logic [ACC_W-1:0] acc);
        logic [SH_W-1:0]   sh;
        logic [DIFF_W-1:0] diff;
        logic [COEF_W-1:0] res;
        sh   = acc[ACC_W-1:FRAC_W];
        diff = {{(DIFF_W - COEF_W){base[COEF_W-1]}}, base} - {sh[SH_W-1], sh};
        if ((&diff[DIFF_W-1:COEF_W-1]) || !(|diff[DIFF_W-1:COEF_W-1])) begin
            res = diff[COEF_W-1:0];
        end else if (diff[DIFF_W-1]) begin
            res = {1'b1, {(COEF_W - 1){1'b0}}};
        end else begin
            res = {1'b0, {(COEF_W - 1){1'b1}}};
        end
        return res;
    endfunction

    always_comb begin
        p_sel = (i_ctl.op[2] ^ i_ctl.op[1]) ? i_p_im : i_p_re;
        if (i_ctl.op[0]) begin
            mul_a = {p_sel[COEF_W-1], p_sel[COEF_W-1:HALF_W]};
        end else begin
            mul_a = {1'b0, p_sel[HALF_W-1:0]};
        end
        mul_b = i_ctl.op[1] ? i_r_im : i_r_re;
        prod  = mul_a * mul_b;
    end

    always_comb begin
        term_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        term     = r_prod_hi ? (term_ext <<< HALF_W) : term_ext;
        if (r_prod_neg) begin
            term = -term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
        r_prod      <= prod;
        r_prod_hi   <= i_ctl.op[0];
        r_prod_neg  <= !i_ctl.op[2] && i_ctl.op[1];
        r_prod_imag <= i_ctl.op[2];
        if (i_ctl.vld && i_ctl.clr) begin
            r_acc_re <= ACC_HALF;
            r_acc_im <= ACC_HALF;
        end else if (r_prod_vld) begin
            if (r_prod_imag) begin
                r_acc_im <= r_acc_im + term;
            end else begin
                r_acc_re <= r_acc_re + term;
            end
        end
    end

    assign o_new_re = sub_sat(i_base_re, r_acc_re);
    assign o_new_im = sub_sat(i_base_im, r_acc_im);

endmodule

`default_nettype wire
